[hdl/spat_pkg.sv]
// Package for the serpentine adaptive threshold block.
// Shared sizes, register map, state type and saturation helpers.
// Used by every module under hdl/ except spat_ram.
`timescale 1ns / 1ps

package spat_pkg;

    // sizes
    localparam int MAX_WIDTH     = 2048;
    localparam int FRACTION_BITS = 9;
    localparam int SUM_BITS      = 20;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS    = 12;
    localparam int DECAY_BITS    = 9;
    localparam int FACTOR_BITS   = 9;
    localparam int INIT_BITS     = 15;
    localparam int PIXEL_BITS    = 8;
    localparam int ADDR_BITS     = 4;
    localparam int DATA_BITS     = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_LINE_WIDTH       = 2'd0;
    localparam logic [1:0] REG_DECAY_WEIGHT     = 2'd1;
    localparam logic [1:0] REG_THRESHOLD_FACTOR = 2'd2;
    localparam logic [1:0] REG_INITIAL_SUM      = 2'd3;

    // register reset values
    localparam logic [WIDTH_BITS-1:0]  RST_LINE_WIDTH       = WIDTH_BITS'(640);
    localparam logic [DECAY_BITS-1:0]  RST_DECAY_WEIGHT     = DECAY_BITS'(506);
    localparam logic [FACTOR_BITS-1:0] RST_THRESHOLD_FACTOR = FACTOR_BITS'(5);
    localparam logic [INIT_BITS-1:0]   RST_INITIAL_SUM      = INIT_BITS'(10160);

    // item sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC
    } t_state;

    // scan position of the item just accepted
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                first_row;
    } t_scan_info;

    // sequencer controls for the arithmetic
    typedef struct packed {
        logic mul_en;
        logic frame_start;
        logic first_row;
    } t_calc_ctrl;

    // saturate a sum that grew by one bit
    function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS:0] v);
        return v[SUM_BITS] ? {SUM_BITS{1'b1}} : v[SUM_BITS-1:0];
    endfunction

    // initial sum brought to sum width, saturating if the sum is narrower
    function automatic logic [SUM_BITS-1:0] init_to_sum(input logic [INIT_BITS-1:0] v);
        logic [SUM_BITS+INIT_BITS-1:0] wide;
        logic [SUM_BITS+INIT_BITS-1:0] top;
        wide = (SUM_BITS+INIT_BITS)'(v);
        top  = (SUM_BITS+INIT_BITS)'({SUM_BITS{1'b1}});
        return (wide > top) ? {SUM_BITS{1'b1}} : wide[SUM_BITS-1:0];
    endfunction

endpackage

[hdl/serpentine_adaptive_threshold.sv]
// Serpentine adaptive threshold: one 1-bit result per 8-bit pixel.
// Steps: the row memory is read at the accepting edge, ST_READ updates the sum, ST_CALC compares.
// A new pixel is accepted only in ST_IDLE, after the previous one has left ST_CALC.
// A waiting result does not block the next accept; it stalls the compare step only.
// Reset: registers to 640/506/5/10160, sum zero, first row, left to right; the row
// memory is not cleared (the first row of a frame uses the initial sum).
`timescale 1ns / 1ps

module serpentine_adaptive_threshold
    import spat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_frame_start,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_is_white,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    // configuration registers
    logic [WIDTH_BITS-1:0]  r_line_width;
    logic [DECAY_BITS-1:0]  r_decay_weight;
    logic [FACTOR_BITS-1:0] r_threshold_factor;
    logic [INIT_BITS-1:0]   r_initial_sum;

    // sequencer and item registers
    t_state                 r_state;
    t_state                 n_state;
    logic [PIXEL_BITS-1:0]  r_pixel;
    logic                   r_frame;
    logic                   r_first;
    logic [COL_BITS-1:0]    r_col;
    logic                   r_out_valid;
    logic                   r_is_white;

    logic                   in_acc;
    logic                   finish;
    logic                   cfg_wr;
    t_scan_info             scan_info;
    t_calc_ctrl             calc_ctrl;
    logic [SUM_BITS-1:0]    ram_rdata;
    logic [SUM_BITS-1:0]    cur_sum;
    logic                   white;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width       <= RST_LINE_WIDTH;
            r_decay_weight     <= RST_DECAY_WEIGHT;
            r_threshold_factor <= RST_THRESHOLD_FACTOR;
            r_initial_sum      <= RST_INITIAL_SUM;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LINE_WIDTH:       r_line_width       <= pwdata[WIDTH_BITS-1:0];
                REG_DECAY_WEIGHT:     r_decay_weight     <= pwdata[DECAY_BITS-1:0];
                REG_THRESHOLD_FACTOR: r_threshold_factor <= pwdata[FACTOR_BITS-1:0];
                REG_INITIAL_SUM:      r_initial_sum      <= pwdata[INIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LINE_WIDTH:       prdata = DATA_BITS'(r_line_width);
            REG_DECAY_WEIGHT:     prdata = DATA_BITS'(r_decay_weight);
            REG_THRESHOLD_FACTOR: prdata = DATA_BITS'(r_threshold_factor);
            REG_INITIAL_SUM:      prdata = DATA_BITS'(r_initial_sum);
            default:              prdata = '0;
        endcase
    end

    // sequencer
    assign in_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        finish     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                // hold the compare until the result register frees up
                if (!r_out_valid || i_out_ready) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pixel <= i_pixel;
            r_frame <= i_frame_start;
            r_first <= scan_info.first_row;
            r_col   <= scan_info.col;
        end
    end

    spat_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_acc),
        .i_frame_start (i_frame_start),
        .i_line_width  (r_line_width),
        .o_info        (scan_info)
    );

    // row sum memory: read at accept, written back when the item finishes
    spat_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (finish),
        .i_waddr (r_col),
        .i_wdata (cur_sum),
        .i_re    (in_acc),
        .i_raddr (scan_info.col),
        .o_rdata (ram_rdata)
    );

    assign calc_ctrl.mul_en      = (r_state == ST_READ);
    assign calc_ctrl.frame_start = r_frame;
    assign calc_ctrl.first_row   = r_first;

    spat_calc u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (calc_ctrl),
        .i_pixel    (r_pixel),
        .i_above    (ram_rdata),
        .i_decay    (r_decay_weight),
        .i_factor   (r_threshold_factor),
        .i_init     (r_initial_sum),
        .o_sum      (cur_sum),
        .o_is_white (white)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_is_white <= white;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_white  = r_is_white;

    // an accepted item always starts with its memory read
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_READ))
        else $error("accepted item did not move to memory read");

    // a full, stalled result register holds the compare step
    a_calc_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && r_out_valid && !i_out_ready) |=> (r_state == ST_CALC))
        else $error("compare step left while result was stalled");

    // a new result only appears when an item finishes
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_CALC))
        else $error("result valid raised outside the compare step");

    // row memory is never read and written in the same cycle
    a_ram_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && finish))
        else $error("row memory read and write overlap");

endmodule

[hdl/spat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/spat_scan.sv]
// Serpentine scan tracker: column position, direction and first-row flag.
// Depends on spat_pkg.
`timescale 1ns / 1ps

module spat_scan
    import spat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_frame_start,
    input  logic [WIDTH_BITS-1:0] i_line_width,
    output t_scan_info            o_info
);

    logic [COL_BITS-1:0]   r_pos;
    logic                  r_rev;
    logic                  r_first;
    logic [COL_BITS-1:0]   n_pos;
    logic                  n_rev;
    logic                  n_first;

    logic [WIDTH_BITS-1:0] w_eff;
    logic [COL_BITS-1:0]   last_col;
    logic [COL_BITS-1:0]   pos;
    logic [COL_BITS-1:0]   pos_c;
    logic                  rev;
    logic                  first;
    logic                  at_end;

    // effective width, clamped to 1..MAX_WIDTH
    always_comb begin
        if (i_line_width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (i_line_width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = i_line_width;
        end
    end

    assign last_col = COL_BITS'(w_eff - WIDTH_BITS'(1));

    // frame start restarts the scan before this pixel
    assign pos   = i_frame_start ? '0 : r_pos;
    assign rev   = i_frame_start ? 1'b0 : r_rev;
    assign first = i_frame_start ? 1'b1 : r_first;

    // a shrunken width makes the pixel the last of its row
    assign pos_c  = (pos > last_col) ? last_col : pos;
    assign at_end = (pos_c == last_col);

    assign o_info.col       = rev ? (last_col - pos_c) : pos_c;
    assign o_info.first_row = first;

    // advance, turning at the row end
    always_comb begin
        n_pos   = r_pos;
        n_rev   = r_rev;
        n_first = r_first;
        if (i_step) begin
            if (at_end) begin
                n_pos   = '0;
                n_rev   = !rev;
                n_first = 1'b0;
            end else begin
                n_pos   = pos_c + COL_BITS'(1);
                n_rev   = rev;
                n_first = first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_rev   <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_pos   <= n_pos;
            r_rev   <= n_rev;
            r_first <= n_first;
        end
    end

endmodule

[hdl/spat_calc.sv]
// Running sum update, row averaging and threshold compare.
// Depends on spat_pkg; fed by the row memory read data.
`timescale 1ns / 1ps

module spat_calc
    import spat_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_calc_ctrl             i_ctrl,
    input  logic [PIXEL_BITS-1:0]  i_pixel,
    input  logic [SUM_BITS-1:0]    i_above,
    input  logic [DECAY_BITS-1:0]  i_decay,
    input  logic [FACTOR_BITS-1:0] i_factor,
    input  logic [INIT_BITS-1:0]   i_init,
    output logic [SUM_BITS-1:0]    o_sum,
    output logic                   o_is_white
);

    localparam int DPROD_BITS = SUM_BITS + DECAY_BITS;
    localparam int TPROD_BITS = SUM_BITS + FACTOR_BITS;

    logic [SUM_BITS-1:0]   r_sum;
    logic [SUM_BITS-1:0]   r_above;
    logic [SUM_BITS-1:0]   init_s;
    logic [SUM_BITS-1:0]   base;
    logic [DPROD_BITS-1:0] decay_prod;
    logic [SUM_BITS:0]     next_raw;
    logic [SUM_BITS:0]     pair;
    logic [SUM_BITS-1:0]   avg;
    logic [TPROD_BITS-1:0] thr_prod;
    logic [TPROD_BITS-1:0] thr;

    assign init_s = init_to_sum(i_init);

    // leaky sum: (sum * decay) >> F + pixel, reloaded on frame start
    assign base       = i_ctrl.frame_start ? init_s : r_sum;
    assign decay_prod = DPROD_BITS'(base) * DPROD_BITS'(i_decay);
    assign next_raw   = (SUM_BITS+1)'(decay_prod >> FRACTION_BITS)
                      + (SUM_BITS+1)'(i_pixel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.mul_en) begin
            r_sum <= sat_sum(next_raw);
        end
    end

    // stored sum from the row above, initial sum on the first row
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_above <= i_ctrl.first_row ? init_s : i_above;
        end
    end

    // average, scale, compare
    assign pair       = {1'b0, r_sum} + {1'b0, r_above};
    assign avg        = pair[SUM_BITS:1];
    assign thr_prod   = TPROD_BITS'(avg) * TPROD_BITS'(i_factor);
    assign thr        = thr_prod >> FRACTION_BITS;
    assign o_is_white = !(TPROD_BITS'(i_pixel) < thr);
    assign o_sum      = r_sum;

endmodule

[tb/tb_serpentine_adaptive_threshold.sv]
// Testbench for serpentine_adaptive_threshold: serpentine pixel stream in, 1-bit result out.
// Holds its own bit-accurate predictor and checks each result; config via the APB-style port.
// Depends on spat_pkg and the serpentine_adaptive_threshold module.
`timescale 1ns / 1ps

module tb_serpentine_adaptive_threshold;
    import spat_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int HANG_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 12;
    localparam int RANDOM_PIXELS = 750;
    localparam int WIDE_PIXELS   = 256;
    localparam int THRESH_PCT    = 15;
    localparam int GRAY_MID      = 127;
    localparam int ONE_FIXED     = 1 << FRACTION_BITS;

    // clock, reset and block inputs, all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  in_valid      = 1'b0;
    logic [PIXEL_BITS-1:0] pixel         = '0;
    logic                  frame_start   = 1'b0;
    logic                  out_ready     = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_BITS-1:0]  paddr         = '0;
    logic [DATA_BITS-1:0]  pwdata        = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_is_white;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    // register copies
    logic [WIDTH_BITS-1:0]  cfg_width;
    logic [DECAY_BITS-1:0]  cfg_decay;
    logic [FACTOR_BITS-1:0] cfg_factor;
    logic [INIT_BITS-1:0]   cfg_init;

    // scan state of the predictor
    logic [SUM_BITS-1:0] scan_sum;
    int                  scan_pos;
    logic                scan_rtl;
    logic                scan_top_row;
    logic [SUM_BITS-1:0] prev_row_sums [MAX_WIDTH];

    logic white_expected [$];
    int   errors       = 0;
    int   pixels_sent  = 0;
    int   in_gap_max   = 8;
    int   out_stall_max = 8;
    int   idle_cycles  = 0;

    serpentine_adaptive_threshold dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (pixel),
        .i_frame_start (frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_is_white    (o_is_white),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor: advance the scan by one pixel and return the expected is_white
    function automatic logic predict_white(input logic [PIXEL_BITS-1:0] pix, input logic fs);
        int                              eff_w;
        int                              col;
        logic [SUM_BITS+DECAY_BITS-1:0]  decayed;
        logic [SUM_BITS:0]               grown;
        logic [SUM_BITS-1:0]             above;
        logic [SUM_BITS:0]               pair;
        logic [SUM_BITS+FACTOR_BITS-1:0] scaled;
        logic [SUM_BITS+FACTOR_BITS-1:0] thr;
        logic                            white;
        eff_w = (cfg_width == '0) ? 1 : int'(cfg_width);
        if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
        if (fs) begin
            scan_sum     = SUM_BITS'(cfg_init);
            scan_pos     = 0;
            scan_rtl     = 1'b0;
            scan_top_row = 1'b1;
        end
        // width shrunk under the current position: this pixel closes the row
        if (scan_pos > eff_w - 1) scan_pos = eff_w - 1;
        col = scan_rtl ? (eff_w - 1 - scan_pos) : scan_pos;
        decayed  = (SUM_BITS+DECAY_BITS)'(scan_sum) * (SUM_BITS+DECAY_BITS)'(cfg_decay);
        grown    = (SUM_BITS+1)'(decayed >> FRACTION_BITS) + (SUM_BITS+1)'(pix);
        scan_sum = grown[SUM_BITS] ? {SUM_BITS{1'b1}} : grown[SUM_BITS-1:0];
        above    = scan_top_row ? SUM_BITS'(cfg_init) : prev_row_sums[COL_BITS'(col)];
        pair     = {1'b0, scan_sum} + {1'b0, above};
        prev_row_sums[COL_BITS'(col)] = scan_sum;
        scaled = (SUM_BITS+FACTOR_BITS)'(pair[SUM_BITS:1])
               * (SUM_BITS+FACTOR_BITS)'(cfg_factor);
        thr    = scaled >> FRACTION_BITS;
        white  = ((SUM_BITS+FACTOR_BITS)'(pix) < thr) ? 1'b0 : 1'b1;
        // serpentine turn at the row end
        if (scan_pos == eff_w - 1) begin
            scan_pos     = 0;
            scan_rtl     = ~scan_rtl;
            scan_top_row = 1'b0;
        end else begin
            scan_pos++;
        end
        return white;
    endfunction

    // one pixel item: random gap, then hold valid until accepted
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic fs);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        pixel       <= pix;
        frame_start <= fs;
        do @(posedge i_clk); while (!o_in_ready);
        white_expected.push_back(predict_white(pix, fs));
        pixels_sent++;
    endtask

    // stop sending and wait until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (white_expected.size() != 0) @(posedge i_clk);
    endtask

    // one APB transfer: setup, access, then back to idle
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [DATA_BITS-1:0] wdata,
                              output logic [DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // read a register back and compare with the held copy
    task automatic check_reg(input logic [1:0] idx);
        logic [DATA_BITS-1:0] got;
        logic [DATA_BITS-1:0] want;
        apb_access(1'b0, idx, '0, got);
        case (idx)
            REG_LINE_WIDTH:       want = DATA_BITS'(cfg_width);
            REG_DECAY_WEIGHT:     want = DATA_BITS'(cfg_decay);
            REG_THRESHOLD_FACTOR: want = DATA_BITS'(cfg_factor);
            default:              want = DATA_BITS'(cfg_init);
        endcase
        if (got !== want) begin
            errors++;
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, idx, want, got);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
        logic [DATA_BITS-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_LINE_WIDTH:       cfg_width  = value[WIDTH_BITS-1:0];
            REG_DECAY_WEIGHT:     cfg_decay  = value[DECAY_BITS-1:0];
            REG_THRESHOLD_FACTOR: cfg_factor = value[FACTOR_BITS-1:0];
            default:              cfg_init   = value[INIT_BITS-1:0];
        endcase
        check_reg(idx);
    endtask

    // width plus the software-derived settings for a window of s pixels
    task automatic set_window(input int w, input int s);
        write_reg(REG_LINE_WIDTH, w);
        write_reg(REG_DECAY_WEIGHT, ONE_FIXED - ONE_FIXED / s);
        write_reg(REG_THRESHOLD_FACTOR, ONE_FIXED * (100 - THRESH_PCT) / (100 * s));
        write_reg(REG_INITIAL_SUM, GRAY_MID * s);
    endtask

    // pick idle behavior for the next phase, sometimes none at all
    task automatic pick_idling();
        in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 8;
        out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
    endtask

    // reset values read back, pixels without any frame start
    task automatic test_reset_defaults();
        for (int r = 0; r < 4; r++) check_reg(2'(r));
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h7f, 1'b0);
        send_pixel(8'h80, 1'b0);
    endtask

    // short rows with turns, pixel extremes and a frame start mid-frame
    task automatic test_frame_rows();
        wait_drained();
        set_window(4, 8);
        for (int i = 0; i < 12; i++)
            send_pixel((i % 3 == 0) ? 8'h00 : 8'hff, (i == 0) || (i == 7));
    endtask

    // line width zero acts as one pixel per row
    task automatic test_zero_width();
        wait_drained();
        write_reg(REG_LINE_WIDTH, 0);
        for (int i = 0; i < 4; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);
    endtask

    // width shrunk while the position already lies past the new width
    task automatic test_width_shrink();
        wait_drained();
        set_window(4, 2);
        for (int i = 0; i < 11; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);
        wait_drained();
        write_reg(REG_LINE_WIDTH, 2);
        for (int i = 0; i < 4; i++)
            send_pixel(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // extreme decay, factor and initial sum
    task automatic test_register_extremes();
        logic [DATA_BITS-1:0] decays  [3];
        logic [DATA_BITS-1:0] factors [3];
        logic [DATA_BITS-1:0] inits   [3];
        decays  = '{0, 511, 511};
        factors = '{511, 0, 511};
        inits   = '{0, 32767, 32767};
        for (int c = 0; c < 3; c++) begin
            wait_drained();
            write_reg(REG_LINE_WIDTH, 4);
            write_reg(REG_DECAY_WEIGHT, decays[c]);
            write_reg(REG_THRESHOLD_FACTOR, factors[c]);
            write_reg(REG_INITIAL_SUM, inits[c]);
            for (int i = 0; i < 5; i++)
                send_pixel(8'($urandom_range(0, 255)), i == 0);
        end
    endtask

    // register above the maximum width: a long first row at the clamped width
    task automatic test_widest_line();
        wait_drained();
        pick_idling();
        set_window(4095, 64);
        for (int i = 0; i < WIDE_PIXELS; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);
    endtask

    // random frames: small widths mostly, image-like content, stray frame starts
    task automatic test_random_frames();
        int goal;
        int w;
        int s;
        int rows;
        int n;
        int bg;
        int ink;
        int k;
        int level;
        logic fs;
        goal = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < goal) begin
            wait_drained();
            pick_idling();
            k = $urandom_range(0, 19);
            if (k == 0)      w = $urandom_range(41, 300);
            else if (k < 4)  w = $urandom_range(1, 7);
            else             w = $urandom_range(8, 40);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(2, 64);
            set_window(w, s);
            // raw register values now and then, so every register bit moves
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_DECAY_WEIGHT, $urandom_range(0, 511));
                write_reg(REG_THRESHOLD_FACTOR, $urandom_range(0, 511));
                write_reg(REG_INITIAL_SUM, $urandom_range(0, 32767));
            end
            rows = (w > 40) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            n    = w * rows + $urandom_range(0, w - 1);
            bg   = $urandom_range(90, 240);
            ink  = $urandom_range(0, 70);
            for (int i = 0; i < n; i++) begin
                k = $urandom_range(0, 15);
                if (k == 0)      level = $urandom_range(0, 255);
                else if (k == 1) level = $urandom_range(0, 1) ? 255 : 0;
                else if (k < 5)  level = ink + $urandom_range(0, 20);
                else             level = bg + $urandom_range(0, 15);
                fs = (i == 0) || ($urandom_range(0, 63) == 0);
                send_pixel(8'(level), fs);
            end
        end
    endtask

    // result side: random stall per item, then ready until one is taken
    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        logic want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (white_expected.size() == 0) begin
                errors++;
                $display("%0t: is_white with none pending, expected none, actual %0b",
                         $time, o_is_white);
            end else begin
                want = white_expected.pop_front();
                if (o_is_white !== want) begin
                    errors++;
                    $display("%0t: is_white mismatch, expected %0b, actual %0b",
                             $time, want, o_is_white);
                end
            end
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, HANG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        cfg_width    = RST_LINE_WIDTH;
        cfg_decay    = RST_DECAY_WEIGHT;
        cfg_factor   = RST_THRESHOLD_FACTOR;
        cfg_init     = RST_INITIAL_SUM;
        scan_sum     = '0;
        scan_pos     = 0;
        scan_rtl     = 1'b0;
        scan_top_row = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_frame_rows();
        test_zero_width();
        test_width_shrink();
        test_register_extremes();
        test_widest_line();
        test_random_frames();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
